FILE: rtl/core/pdp_pkg.sv
// Shared types and constants for the panorama depth-to-point converter.
// No dependencies; every other file of the block but pdp_queue imports this package.
package pdp_pkg;

   localparam int COORD_W = 10;                 // pixel column and row
   localparam int CODE_W  = 8;                  // depth sample
   localparam int CFG_W   = 24;                 // unsigned Q16.8 distance
   localparam int POINT_W = 25;                 // signed Q16.8 coordinate
   localparam int PROD_W  = CODE_W + CFG_W;     // code times span
   localparam int TRIG_W  = 16;                 // trig magnitude, 1.0 = 2^15
   localparam int CSR_IDX_W = 1;

   localparam int QUEUE_DEPTH = 4;

   // pi in Q30, for building the quarter-wave sine table
   localparam logic [63:0] PI_Q30 = 64'd3373259426;

   // x / 255 == (x * DIV255_MAGIC) >> DIV255_SHIFT for every 32-bit x
   localparam logic [31:0] CODE_ROUND   = 32'd127;
   localparam logic [63:0] DIV255_MAGIC = 64'h0000_0000_8080_8081;
   localparam int          DIV255_SHIFT = 39;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DEPTH_MIN = 1'b0,
      REG_DEPTH_MAX = 1'b1
   } csr_reg_type;

   // Distance mapping derived from the two registers
   typedef struct packed {
      logic [CFG_W-1:0] depth_min;
      logic [CFG_W-1:0] span;
      logic             span_neg;
   } pdp_cfg_type;

endpackage

FILE: rtl/core/pdp_if.sv
// Channel interfaces: pixel requests in, Cartesian points out.
// Depends on pdp_pkg for field widths.
interface pdp_req_if;
   import pdp_pkg::*;
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] column;
   logic [COORD_W-1:0] row;
   logic [CODE_W-1:0]  depth_code;

   modport source (output valid, output column, output row, output depth_code, input ready);
   modport sink   (input valid, input column, input row, input depth_code, output ready);
endinterface

interface pdp_rsp_if;
   import pdp_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [POINT_W-1:0] point_x;
   logic signed [POINT_W-1:0] point_y;
   logic signed [POINT_W-1:0] point_z;

   modport source (output valid, output point_x, output point_y, output point_z, input ready);
   modport sink   (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

FILE: rtl/core/pdp_front.sv
// Front end: accepts pixels, drops empty ones, forms the depth product and
// the four angle indices reduced to one turn. Depends on pdp_pkg, pdp_if.
module pdp_front #(
   parameter int STEPS_PER_HALF_TURN = 360,
   parameter int CENTER_COLUMN       = 360
) (
   pdp_req_if.sink              req_bus,
   input  pdp_pkg::pdp_cfg_type cfg,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [pdp_pkg::PROD_W + 4*$clog2(4*STEPS_PER_HALF_TURN)-1:0] out_data
);
   import pdp_pkg::*;

   localparam int S     = STEPS_PER_HALF_TURN;
   localparam int TURN  = 4 * S;
   localparam int TW    = $clog2(TURN);
   localparam int C2    = (2 * CENTER_COLUMN) % TURN;
   localparam int VMAX  = 2 * ((1 << COORD_W) - 1) + TURN + S;
   localparam int VW    = $clog2(VMAX + 1);
   localparam int RECIP = (1 << VW) / TURN;
   localparam int RW    = $clog2(RECIP + 1);

   // v mod TURN: reciprocal estimate is at most one low, fix with one subtract
   function automatic logic [TW-1:0] wrap_turn(input logic [VW-1:0] v);
      logic [VW+RW-1:0] prod_v;
      logic [RW-1:0]    q_est;
      logic [VW-1:0]    r;
      prod_v = (VW+RW)'(v) * (VW+RW)'(RECIP);
      q_est  = RW'(prod_v >> VW);
      r      = v - VW'(q_est * TURN);
      if (r >= VW'(TURN)) begin
         r = r - VW'(TURN);
      end
      return TW'(r);
   endfunction

   logic [VW-1:0]     v_theta_sin;
   logic [VW-1:0]     v_theta_cos;
   logic [VW-1:0]     v_phi_sin;
   logic [VW-1:0]     v_phi_cos;
   logic [PROD_W-1:0] depth_prod;

   always_comb begin
      v_theta_sin = VW'({req_bus.row, 1'b0});
      v_theta_cos = v_theta_sin + VW'(S);
      v_phi_sin   = VW'({req_bus.column, 1'b0}) + VW'(TURN - C2);
      v_phi_cos   = v_phi_sin + VW'(S);
      depth_prod  = PROD_W'(req_bus.depth_code) * PROD_W'(cfg.span);
   end

   // drop zero codes here; they never reach the queue
   assign out_valid     = req_bus.valid && (req_bus.depth_code != '0);
   assign req_bus.ready = out_ready;
   assign out_data      = {depth_prod, wrap_turn(v_theta_sin), wrap_turn(v_theta_cos),
                           wrap_turn(v_phi_sin), wrap_turn(v_phi_cos)};

endmodule

FILE: rtl/core/pdp_queue.sv
// Short FIFO between front and back end, registers only.
// Depends on nothing but its parameters.
module pdp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push;
   logic             pop;

   assign in_ready  = (count_ff != CW'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue fill count beyond depth");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> count_ff == CW'($past(count_ff) + CW'($past(push)) - CW'($past(pop))))
      else $error("queue fill count lost a beat");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (rd_ptr_ff != wr_ptr_ff) |-> (count_ff != '0 && count_ff != CW'(DEPTH)))
      else $error("queue pointers disagree with fill count");

endmodule

FILE: rtl/core/pdp_back.sv
// Back end: distance rescale, sine table lookup and the coordinate products
// in a five-stage pipeline that stalls as a whole. Depends on pdp_pkg, pdp_if.
module pdp_back #(
   parameter int STEPS_PER_HALF_TURN = 360
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pdp_pkg::pdp_cfg_type cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [pdp_pkg::PROD_W + 4*$clog2(4*STEPS_PER_HALF_TURN)-1:0] in_data,
   pdp_rsp_if.source            rsp_bus
);
   import pdp_pkg::*;

   localparam int S    = STEPS_PER_HALF_TURN;
   localparam int HALF = 2 * S;
   localparam int TW   = $clog2(4 * S);
   localparam int AW   = $clog2(S + 1);
   localparam int PSTW = CFG_W + TRIG_W;
   localparam int PXW  = PSTW + TRIG_W;

   // quarter-wave sine table, two copies with two read ports each
   logic [TRIG_W-1:0] rom_theta [0:S];
   logic [TRIG_W-1:0] rom_phi   [0:S];

   for (genvar g = 0; g <= S; g++) begin : g_rom
      localparam logic [63:0] A   = (64'(g) * PI_Q30) / 64'(HALF);
      localparam logic [63:0] A2  = (A * A) >> 30;
      localparam logic [63:0] T1  = ((A  * A2) >> 30) / 64'd6;
      localparam logic [63:0] T2  = ((T1 * A2) >> 30) / 64'd20;
      localparam logic [63:0] T3  = ((T2 * A2) >> 30) / 64'd42;
      localparam logic [63:0] T4  = ((T3 * A2) >> 30) / 64'd72;
      localparam logic [63:0] T5  = ((T4 * A2) >> 30) / 64'd110;
      localparam logic [63:0] T6  = ((T5 * A2) >> 30) / 64'd156;
      localparam logic [63:0] T7  = ((T6 * A2) >> 30) / 64'd210;
      localparam logic [63:0] T8  = ((T7 * A2) >> 30) / 64'd272;
      localparam logic [63:0] SUM = A - T1 + T2 - T3 + T4 - T5 + T6 - T7 + T8;
      localparam logic [63:0] MAG = (SUM + 64'd16384) >> 15;
      assign rom_theta[g] = MAG[TRIG_W-1:0];
      assign rom_phi[g]   = MAG[TRIG_W-1:0];
   end

   // fold a full-turn index onto the quarter wave: {negative, table index}
   function automatic logic [AW:0] fold(input logic [TW-1:0] m);
      logic          neg;
      logic [TW-1:0] m2;
      neg = (m >= TW'(HALF));
      m2  = neg ? m - TW'(HALF) : m;
      if (m2 > TW'(S)) begin
         m2 = TW'(HALF) - m2;
      end
      return {neg, AW'(m2)};
   endfunction

   logic              en;
   logic [PROD_W-1:0] q_prod;
   logic [AW:0]       f_ts, f_tc, f_ps, f_pc;
   logic [63:0]       div_prod;

   // stage 1: table read, divide by 255
   logic              v1_ff;
   logic [CFG_W-1:0]  q1_ff;
   logic [TRIG_W-1:0] st1_ff, ct1_ff, sp1_ff, cp1_ff;
   logic [3:0]        sgn1_ff;
   // stage 2: distance
   logic              v2_ff;
   logic [CFG_W-1:0]  d2_ff;
   logic [TRIG_W-1:0] st2_ff, ct2_ff, sp2_ff, cp2_ff;
   logic [3:0]        sgn2_ff;
   // stage 3: distance times polar terms
   logic              v3_ff;
   logic [PSTW-1:0]   pst3_ff, pct3_ff;
   logic [TRIG_W-1:0] sp3_ff, cp3_ff;
   logic [2:0]        sgn3_ff;
   // stage 4: azimuth products, y rounding
   logic              v4_ff;
   logic [PXW-1:0]    px4_ff, pz4_ff;
   logic [POINT_W-1:0] ym4_ff;
   logic [2:0]        sgn4_ff;
   // stage 5: output register
   logic               v5_ff;
   logic [POINT_W-1:0] x5_ff, y5_ff, z5_ff;

   logic [PSTW-1:0]    y_round;
   logic [PXW-1:0]     x_round, z_round;
   logic [POINT_W-1:0] xm, zm;

   // advance everything when the output slot is free or being taken
   assign en       = !v5_ff || rsp_bus.ready;
   assign in_ready = en;

   always_comb begin
      q_prod   = in_data[PROD_W + 4*TW - 1 -: PROD_W];
      f_ts     = fold(in_data[4*TW-1 -: TW]);
      f_tc     = fold(in_data[3*TW-1 -: TW]);
      f_ps     = fold(in_data[2*TW-1 -: TW]);
      f_pc     = fold(in_data[TW-1:0]);
      div_prod = 64'(q_prod + CODE_ROUND) * DIV255_MAGIC;
      y_round  = pct3_ff + PSTW'(1 << 14);
      x_round  = px4_ff + (PXW'(1) << 29);
      z_round  = pz4_ff + (PXW'(1) << 29);
      xm       = x_round[POINT_W+29:30];
      zm       = z_round[POINT_W+29:30];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q1_ff   <= div_prod[DIV255_SHIFT+CFG_W-1:DIV255_SHIFT];
         st1_ff  <= rom_theta[f_ts[AW-1:0]];
         ct1_ff  <= rom_theta[f_tc[AW-1:0]];
         sp1_ff  <= rom_phi[f_ps[AW-1:0]];
         cp1_ff  <= rom_phi[f_pc[AW-1:0]];
         sgn1_ff <= {f_ts[AW], f_tc[AW], f_ps[AW], f_pc[AW]};

         d2_ff   <= cfg.span_neg ? cfg.depth_min - q1_ff : cfg.depth_min + q1_ff;
         st2_ff  <= st1_ff;
         ct2_ff  <= ct1_ff;
         sp2_ff  <= sp1_ff;
         cp2_ff  <= cp1_ff;
         sgn2_ff <= sgn1_ff;

         pst3_ff <= PSTW'(d2_ff) * PSTW'(st2_ff);
         pct3_ff <= PSTW'(d2_ff) * PSTW'(ct2_ff);
         sp3_ff  <= sp2_ff;
         cp3_ff  <= cp2_ff;
         // x sign, y sign, z sign
         sgn3_ff <= {sgn2_ff[3] ^ sgn2_ff[1], sgn2_ff[2], sgn2_ff[3] ^ sgn2_ff[0]};

         px4_ff  <= PXW'(pst3_ff) * PXW'(sp3_ff);
         pz4_ff  <= PXW'(pst3_ff) * PXW'(cp3_ff);
         ym4_ff  <= y_round[POINT_W+14:15];
         sgn4_ff <= sgn3_ff;

         x5_ff   <= sgn4_ff[2] ? POINT_W'(0) - xm     : xm;
         y5_ff   <= sgn4_ff[1] ? POINT_W'(0) - ym4_ff : ym4_ff;
         z5_ff   <= sgn4_ff[0] ? POINT_W'(0) - zm     : zm;
      end
   end

   assign rsp_bus.valid   = v5_ff;
   assign rsp_bus.point_x = $signed(x5_ff);
   assign rsp_bus.point_y = $signed(y5_ff);
   assign rsp_bus.point_z = $signed(z5_ff);

endmodule

FILE: rtl/core/panorama_depth_to_point.sv
// Panorama depth-to-point converter, top level: configuration registers,
// front end, queue and back end. Depends on pdp_pkg, pdp_if and the pdp_ modules.
// A pixel with a nonzero code is registered in the queue, then in each back-end stage, before it
// shows on rsp. Throughput: one pixel per cycle while rsp is ready, set by the back-end pipeline.
// Zero-code pixels are taken and produce nothing. Reset clears the registers to 0,
// the queue and all pipeline valids; there is no clearing pass.
module panorama_depth_to_point #(
   parameter int STEPS_PER_HALF_TURN = 360,
   parameter int CENTER_COLUMN       = 360
) (
   input  logic                             clock,
   input  logic                             reset,
   pdp_req_if.sink                          req_bus,
   pdp_rsp_if.source                        rsp_bus,
   input  logic                             csr_we,
   input  logic [pdp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pdp_pkg::CFG_W-1:0]        csr_wdata
);
   import pdp_pkg::*;

   localparam int TW = $clog2(4 * STEPS_PER_HALF_TURN);
   localparam int QW = PROD_W + 4 * TW;

   logic [CFG_W-1:0] depth_min_ff, depth_min_in;
   logic [CFG_W-1:0] depth_max_ff, depth_max_in;
   logic [CFG_W-1:0] span_ff, span_in;
   logic             span_neg_ff, span_neg_in;
   pdp_cfg_type      cfg;

   logic          f_valid, f_ready;
   logic [QW-1:0] f_data;
   logic          b_valid, b_ready;
   logic [QW-1:0] b_data;

   // span and its sign follow the register write in the same cycle
   always_comb begin
      depth_min_in = depth_min_ff;
      depth_max_in = depth_max_ff;
      if (csr_we) begin
         case (csr_reg_type'(csr_index))
            REG_DEPTH_MIN: depth_min_in = csr_wdata;
            REG_DEPTH_MAX: depth_max_in = csr_wdata;
            default: ;
         endcase
      end
      span_neg_in = (depth_max_in < depth_min_in);
      span_in     = span_neg_in ? depth_min_in - depth_max_in : depth_max_in - depth_min_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_min_ff <= '0;
         depth_max_ff <= '0;
         span_ff      <= '0;
         span_neg_ff  <= 1'b0;
      end else begin
         depth_min_ff <= depth_min_in;
         depth_max_ff <= depth_max_in;
         span_ff      <= span_in;
         span_neg_ff  <= span_neg_in;
      end
   end

   assign cfg.depth_min = depth_min_ff;
   assign cfg.span      = span_ff;
   assign cfg.span_neg  = span_neg_ff;

   pdp_front #(
      .STEPS_PER_HALF_TURN (STEPS_PER_HALF_TURN),
      .CENTER_COLUMN       (CENTER_COLUMN)
   ) u_front (
      .req_bus   (req_bus),
      .cfg       (cfg),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_data  (f_data)
   );

   pdp_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_data),
      .out_valid (b_valid),
      .out_ready (b_ready),
      .out_data  (b_data)
   );

   pdp_back #(
      .STEPS_PER_HALF_TURN (STEPS_PER_HALF_TURN)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_valid (b_valid),
      .in_ready (b_ready),
      .in_data  (b_data),
      .rsp_bus  (rsp_bus)
   );

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// Testbench for panorama_depth_to_point: streams pixels under several distance settings
// and checks every returned point against a fixed-point predictor held in a scoreboard.
// Depends on pdp_pkg, the pdp_req_if / pdp_rsp_if interfaces and the block's RTL.
module testbench;
   import pdp_pkg::*;

   localparam int HALF_TURN     = 360;
   localparam int CENTER_COL    = 360;
   localparam int FULL_TURN     = 4 * HALF_TURN;   // table steps of pi/(2*HALF_TURN)
   localparam int TURN_W        = $clog2(FULL_TURN);
   localparam int DRAIN_CYCLES  = 10;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_PIXELS  = 155;
   localparam int DIRECTED_N    = 21;
   localparam int DIR_W         = $clog2(DIRECTED_N);

   // column, row, depth code
   localparam int DIRECTED_PIXELS [DIRECTED_N][3] = '{
      '{0, 0, 255},     '{719, 719, 255},  '{360, 360, 1},    '{360, 180, 255},
      '{0, 360, 255},   '{180, 360, 128},  '{540, 360, 200},  '{719, 0, 1},
      '{1023, 1023, 255}, '{1023, 0, 77},  '{0, 1023, 33},    '{360, 720, 255},
      '{359, 540, 255}, '{361, 90, 255},   '{0, 0, 0},        '{719, 719, 0},
      '{512, 512, 170}, '{85, 682, 85},    '{360, 0, 255},    '{720, 719, 254},
      '{1, 1, 2}
   };

   typedef struct packed {
      logic [POINT_W-1:0] x;
      logic [POINT_W-1:0] y;
      logic [POINT_W-1:0] z;
   } point_type;

   class point_scoreboard;
      logic [CFG_W-1:0] depth_min;
      logic [CFG_W-1:0] depth_max;
      int               sine_q15 [FULL_TURN];
      point_type        expected_points [$];
      int               errors;

      function new();
         depth_min = '0;
         depth_max = '0;
         errors    = 0;
         for (int m = 0; m < FULL_TURN; m++) sine_q15[TURN_W'(m)] = series_sine(m);
      endfunction

      // Taylor series in Q30 over a quarter wave, folded by symmetry
      function int series_sine(int unsigned step);
         int unsigned half_steps = FULL_TURN / 2;
         bit          neg = 1'b0;
         logic [63:0] a, a2, sum, term, mag;
         step = step % FULL_TURN;
         if (step >= half_steps) begin
            neg  = 1'b1;
            step = step - half_steps;
         end
         if (step > HALF_TURN) step = half_steps - step;
         a    = (64'(step) * PI_Q30) / half_steps;
         a2   = (a * a) >> 30;
         sum  = a;
         term = a;
         for (int n = 1; n <= 8; n++) begin
            term = ((term * a2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) sum = sum - term;
            else sum = sum + term;
         end
         mag = (sum + (64'd1 << 14)) >> 15;
         return neg ? -int'(mag) : int'(mag);
      endfunction

      function logic [63:0] magnitude(int v);
         return (v < 0) ? 64'(-v) : 64'(v);
      endfunction

      function logic [POINT_W-1:0] signed_coord(logic [63:0] mag, bit neg);
         logic [63:0] v;
         v = neg ? -mag : mag;
         return v[POINT_W-1:0];
      endfunction

      function void set_reg(csr_reg_type index, logic [CFG_W-1:0] value);
         case (index)
            REG_DEPTH_MIN: depth_min = value;
            REG_DEPTH_MAX: depth_max = value;
            default: ;
         endcase
      endfunction

      function void note_pixel(logic [COORD_W-1:0] column, logic [COORD_W-1:0] row,
                               logic [CODE_W-1:0] code);
         bit                span_neg;
         logic [63:0]       span, q, d;
         int unsigned       phi_step;
         logic [TURN_W-1:0] st_idx, ct_idx, sp_idx, cp_idx;
         int                st, ct, sp, cp;
         point_type         p;
         if (code == 0) return;
         span_neg = depth_max < depth_min;
         span = span_neg ? 64'(depth_min - depth_max) : 64'(depth_max - depth_min);
         q = (64'(code) * span + 64'd127) / 64'd255;
         d = span_neg ? 64'(depth_min) - q : 64'(depth_min) + q;
         phi_step = (2 * int'(column) + FULL_TURN - (2 * CENTER_COL) % FULL_TURN) % FULL_TURN;
         st_idx = TURN_W'((2 * int'(row)) % FULL_TURN);
         ct_idx = TURN_W'((2 * int'(row) + HALF_TURN) % FULL_TURN);
         sp_idx = TURN_W'(phi_step);
         cp_idx = TURN_W'((phi_step + HALF_TURN) % FULL_TURN);
         st = sine_q15[st_idx];
         ct = sine_q15[ct_idx];
         sp = sine_q15[sp_idx];
         cp = sine_q15[cp_idx];
         p.x = signed_coord((d * magnitude(st) * magnitude(sp) + (64'd1 << 29)) >> 30,
                            (st < 0) != (sp < 0));
         p.y = signed_coord((d * magnitude(ct) + (64'd1 << 14)) >> 15, ct < 0);
         p.z = signed_coord((d * magnitude(st) * magnitude(cp) + (64'd1 << 29)) >> 30,
                            (st < 0) != (cp < 0));
         expected_points = {expected_points, p};
      endfunction

      function void check_point(logic [POINT_W-1:0] x, logic [POINT_W-1:0] y,
                                logic [POINT_W-1:0] z);
         point_type want;
         if (expected_points.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected point (%0d, %0d, %0d)", $signed(x), $signed(y), $signed(z));
            return;
         end
         want = expected_points.pop_front();
         if (x !== want.x || y !== want.y || z !== want.z) begin
            errors++;
            if (errors <= 10)
               $display("point mismatch: expected (%0d, %0d, %0d), got (%0d, %0d, %0d)",
                        $signed(want.x), $signed(want.y), $signed(want.z),
                        $signed(x), $signed(y), $signed(z));
         end
      endfunction

      function int pending();
         return expected_points.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_we;
   csr_reg_type       csr_index;
   logic [CFG_W-1:0]  csr_wdata;
   int unsigned       cycle_count = 0;
   bit                sender_burst = 1'b0;
   bit                receiver_burst = 1'b0;
   point_scoreboard   board;

   pdp_req_if pixel_bus ();
   pdp_rsp_if point_bus ();

   panorama_depth_to_point #(
      .STEPS_PER_HALF_TURN(HALF_TURN),
      .CENTER_COLUMN(CENTER_COL)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_bus(pixel_bus),
      .rsp_bus(point_bus),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   task automatic send_pixel(input logic [COORD_W-1:0] column, input logic [COORD_W-1:0] row,
                             input logic [CODE_W-1:0] code);
      int gap;
      if ($urandom_range(0, 39) == 0) sender_burst = !sender_burst;
      gap = sender_burst ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         pixel_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      pixel_bus.valid      <= 1'b1;
      pixel_bus.column     <= column;
      pixel_bus.row        <= row;
      pixel_bus.depth_code <= code;
      do @(posedge clock); while (!pixel_bus.ready);
      board.note_pixel(column, row, code);
   endtask

   task automatic random_pixel();
      logic [COORD_W-1:0] column, row;
      logic [CODE_W-1:0]  code;
      int                 pick;
      // mostly on the panorama, sometimes anywhere in the 10-bit field
      column = ($urandom_range(0, 4) == 0) ? COORD_W'($urandom_range(0, 1023))
                                           : COORD_W'($urandom_range(0, 719));
      row    = ($urandom_range(0, 4) == 0) ? COORD_W'($urandom_range(0, 1023))
                                           : COORD_W'($urandom_range(0, 719));
      pick   = $urandom_range(0, 19);
      case (pick)
         0, 1:    code = '0;
         2:       code = 8'd255;
         3:       code = 8'd1;
         default: code = CODE_W'($urandom_range(1, 255));
      endcase
      send_pixel(column, row, code);
   endtask

   // Hold off until every point is back, then keep the pixel bus idle before returning
   task automatic settle();
      pixel_bus.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_reg_type index, input logic [CFG_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      board.set_reg(index, value);
   endtask

   task automatic set_distances(input logic [CFG_W-1:0] near, input logic [CFG_W-1:0] far);
      write_reg(REG_DEPTH_MIN, near);
      write_reg(REG_DEPTH_MAX, far);
      csr_we <= 1'b0;
   endtask

   initial begin
      point_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         int stall;
         if ($urandom_range(0, 39) == 0) receiver_burst = !receiver_burst;
         stall = receiver_burst ? 0 : $urandom_range(0, 8);
         if (stall > 0) begin
            point_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         point_bus.ready <= 1'b1;
         do @(posedge clock); while (!point_bus.valid);
         board.check_point(point_bus.point_x, point_bus.point_y, point_bus.point_z);
      end
   end

   initial begin
      logic [CFG_W-1:0] near, far, swap;
      board = new();
      pixel_bus.valid      <= 1'b0;
      pixel_bus.column     <= '0;
      pixel_bus.row        <= '0;
      pixel_bus.depth_code <= '0;
      csr_we    <= 1'b0;
      csr_index <= REG_DEPTH_MIN;
      csr_wdata <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // registers still at their reset value: every point collapses to the origin
      repeat (20) random_pixel();
      settle();

      set_distances(24'h000100, 24'hFFFFFF);
      for (int i = 0; i < DIRECTED_N; i++)
         send_pixel(COORD_W'(DIRECTED_PIXELS[DIR_W'(i)][2'd0]),
                    COORD_W'(DIRECTED_PIXELS[DIR_W'(i)][2'd1]),
                    CODE_W'(DIRECTED_PIXELS[DIR_W'(i)][2'd2]));
      settle();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         near = CFG_W'($urandom());
         far  = CFG_W'($urandom());
         case (phase)
            0: begin near = '0; far = '1; end
            1: begin near = '1; far = '0; end
            2: begin near = '1; far = '1; end
            3: begin near = '0; far = '0; end
            4: far = near;
            5: if (near < far) begin
                  // falling distances: near end beyond the far end
                  swap = near;
                  near = far;
                  far  = swap;
               end
            default: ;
         endcase
         set_distances(near, far);
         repeat (PHASE_PIXELS) random_pixel();
         settle();
      end

      if (board.errors == 0 && board.pending() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/core/pdp_pkg.sv
rtl/core/pdp_if.sv
rtl/core/pdp_front.sv
rtl/core/pdp_queue.sv
rtl/core/pdp_back.sv
rtl/core/panorama_depth_to_point.sv
dv/testbench.sv
